### rtl/tria_pkg.sv
// Package with payload types, command and status structs and constants of the slot allocator.
`default_nettype none
package tria_pkg;

  localparam int TIME_W     = 32;
  localparam int TAG_W      = 10;
  localparam int SLOT_OUT_W = 11;

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [TAG_W-1:0]  request_tag;
  } alloc_req_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot_id;
    logic [TAG_W-1:0]      result_tag;
    logic [SLOT_OUT_W-1:0] max_slot;
    logic                  exhausted;
  } alloc_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_GRANT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic retire;
    logic pop;
    logic no_slot;
    logic grant;
  } tria_cmd_t;

  typedef struct packed {
    logic holder_nonempty;
    logic expired;
    logic stack_nonempty;
    logic out_free;
  } tria_stat_t;

endpackage
`default_nettype wire

### rtl/timed_release_id_allocator.sv
// Top level of the timed-release slot allocator: controller, datapath and checks.
// Each transaction releases the expired holders at the FIFO head before it takes a
// slot; the holder FIFO read port releases one holder a cycle.
// Input stalls until the last result is granted; each holder is released only once.
// Synchronous active-high reset empties the holder FIFO, fills the free stack and
// clears hold_gap and the peak slot at once; no clearing pass is needed.
`default_nettype none
module timed_release_id_allocator #(
  parameter int SLOTS = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [31:0]          cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tria_pkg::alloc_req_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tria_pkg::alloc_rsp_t      out_data
);
  import tria_pkg::*;

  // Commands flow from the controller to the datapath, status flows back.
  tria_cmd_t  cmd;
  tria_stat_t stat;

  // The controller accepts a transaction only in its idle state. It then releases
  // expired holders from the FIFO head, pops the free stack and finally loads the
  // output register, waiting there while a previous result is still stalled.
  tria_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds both memories. The free stack uses a low-water mark so that
  // entries never written since reset read back as their initial slot number.
  tria_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cmd         (cmd),
    .stat        (stat)
  );

`ifndef SYNTH
  // At most one command is issued in any cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.retire, cmd.pop, cmd.no_slot, cmd.grant}))
    else $error("more than one datapath command in a cycle");

  // An accepted transaction keeps the input side busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction is in progress");

  // A grant always produces a valid result in the next cycle.
  a_grant_out: assert property (@(posedge clk) disable iff (rst)
    cmd.grant |=> out_valid)
    else $error("grant did not load the output register");

  // The stack is popped only when it holds a free slot.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> stat.stack_nonempty)
    else $error("pop from an empty free stack");
`endif

endmodule
`default_nettype wire

### rtl/tria_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tria_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/tria_ctrl.sv
// Controller state machine that sequences capture, release, pop and grant.
`default_nettype none
module tria_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tria_pkg::tria_stat_t stat,
  output tria_pkg::tria_cmd_t       cmd
);
  import tria_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_TEST;
        end
      end
      S_TEST: begin
        // Release expired holders one per cycle, then take a slot off the stack, or flag that none is free.
        priority if (stat.holder_nonempty && stat.expired) begin
          cmd.retire = 1'b1;
        end else if (stat.stack_nonempty) begin
          cmd.pop    = 1'b1;
          state_next = S_GRANT;
        end else begin
          cmd.no_slot = 1'b1;
          state_next  = S_GRANT;
        end
      end
      S_GRANT: begin
        if (stat.out_free) begin
          cmd.grant  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/tria_dpath.sv
// Datapath with holder FIFO, free stack, counters and output register.
`default_nettype none
module tria_dpath #(
  parameter int SLOTS = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wr_en,
  input  wire logic [31:0]             cfg_wr_data,
  input  wire tria_pkg::alloc_req_t    in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output tria_pkg::alloc_rsp_t         out_data,
  input  wire tria_pkg::tria_cmd_t     cmd,
  output tria_pkg::tria_stat_t         stat
);
  import tria_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int SW = $clog2(SLOTS + 1);
  localparam int HW = TIME_W + SW;

  logic [TIME_W-1:0] hold_gap;
  logic [TIME_W-1:0] now_time;
  logic [TAG_W-1:0]  tag;
  logic [SW-1:0]     free_count;
  logic [SW-1:0]     low_mark;
  logic [SW-1:0]     holder_count;
  logic [SW-1:0]     peak;
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic              use_init;
  logic [SW-1:0]     init_val;
  logic              no_slot;

  logic [AW-1:0]     head_next;
  logic [AW-1:0]     tail_next;
  logic [SW-1:0]     pop_idx;
  logic [SW-1:0]     grant_slot;
  logic [SW-1:0]     peak_next;
  logic [HW-1:0]     fifo_rd;
  logic [TIME_W-1:0] h_time;
  logic [SW-1:0]     h_slot;
  logic [SW-1:0]     stack_rd;
  logic              stack_wr_en;
  logic              fifo_wr_en;
  logic              fifo_rd_en;
  logic [AW-1:0]     fifo_rd_addr;

  assign h_time    = fifo_rd[HW-1:SW];
  assign h_slot    = fifo_rd[SW-1:0];
  assign head_next = (head == AW'(SLOTS - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == AW'(SLOTS - 1)) ? '0 : tail + 1'b1;
  assign pop_idx   = free_count - 1'b1;

  assign grant_slot = no_slot ? '0 : (use_init ? init_val : stack_rd);
  assign peak_next  = (!no_slot && (grant_slot > peak)) ? grant_slot : peak;

  assign stack_wr_en  = cmd.retire && (free_count < SW'(SLOTS));
  assign fifo_wr_en   = cmd.grant && !no_slot && (holder_count < SW'(SLOTS));
  assign fifo_rd_en   = cmd.capture || cmd.retire;
  assign fifo_rd_addr = cmd.retire ? head_next : head;

  assign stat.holder_nonempty = (holder_count != '0);
  assign stat.expired         = ({1'b0, h_time} + {1'b0, hold_gap}) < {1'b0, now_time};
  assign stat.stack_nonempty  = (free_count != '0);
  assign stat.out_free        = !out_valid || !out_stall;

  tria_ram #(
    .WIDTH (HW),
    .DEPTH (SLOTS)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_wr_en),
    .wr_addr (tail),
    .wr_data ({now_time, grant_slot}),
    .rd_en   (fifo_rd_en),
    .rd_addr (fifo_rd_addr),
    .rd_data (fifo_rd)
  );

  tria_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stack_wr_en),
    .wr_addr (free_count[AW-1:0]),
    .wr_data (h_slot),
    .rd_en   (cmd.pop),
    .rd_addr (pop_idx[AW-1:0]),
    .rd_data (stack_rd)
  );

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_gap     <= '0;
      free_count   <= SW'(SLOTS);
      low_mark     <= SW'(SLOTS);
      holder_count <= '0;
      peak         <= '0;
      head         <= '0;
      tail         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hold_gap <= cfg_wr_data;
      end
      if (cmd.retire) begin
        if (free_count < SW'(SLOTS)) begin
          free_count <= free_count + 1'b1;
        end
        head         <= head_next;
        holder_count <= holder_count - 1'b1;
      end
      if (cmd.pop) begin
        free_count <= pop_idx;
        if (pop_idx < low_mark) begin
          low_mark <= pop_idx;
        end
      end
      if (cmd.grant) begin
        peak <= peak_next;
        if (fifo_wr_en) begin
          tail         <= tail_next;
          holder_count <= holder_count + 1'b1;
        end
      end
      if (cmd.grant) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_time <= in_data.arrival_time;
      tag      <= in_data.request_tag;
    end
    if (cmd.pop) begin
      // Stack entries below the low-water mark were never written, so their initial slot number is used.
      use_init <= (pop_idx < low_mark);
      init_val <= SW'(SLOTS) - pop_idx;
      no_slot  <= 1'b0;
    end
    if (cmd.no_slot) begin
      no_slot <= 1'b1;
    end
    if (cmd.grant) begin
      out_data.slot_id    <= SLOT_OUT_W'(grant_slot);
      out_data.result_tag <= tag;
      out_data.max_slot   <= SLOT_OUT_W'(peak_next);
      out_data.exhausted  <= no_slot;
    end
  end

endmodule
`default_nettype wire
